[sv/arc_pkg.sv]
// Shared types and codes for the address resolution cache.
// Holds field widths, command and status codes and the structs between modules.
// No dependencies.
`default_nettype none

package arc_pkg;

  localparam int CMD_W    = 2;
  localparam int IP_W     = 32;
  localparam int MAC_W    = 48;
  localparam int STAMP_W  = 64;
  localparam int TO_W     = 32;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;

  localparam logic [TO_W-1:0] TIMEOUT_RESET = 32'd300000;

  localparam logic [CMD_W-1:0] CMD_ADD     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEANUP = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_REFRESHED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_IGNORED   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_HIT       = 3'd4;
  localparam logic [STATUS_W-1:0] ST_MISS      = 3'd5;
  localparam logic [STATUS_W-1:0] ST_CLEANED   = 3'd6;

  typedef struct packed {
    logic [IP_W-1:0]    ip;
    logic [MAC_W-1:0]   mac;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [IP_W-1:0]    ip;
    logic [MAC_W-1:0]   mac;
    logic [STAMP_W-1:0] now;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [MAC_W-1:0]    mac;
    logic [COUNT_W-1:0]  count;
  } res_t;

endpackage

`default_nettype wire

[sv/address_resolution_cache.sv]
// Add, lookup and cleanup scan the entry RAM, one read per slot with registered read
// data, then finish with a write-back (add only) and a registered result on m_tvalid;
// zero-IP add or lookup and unused commands skip the scan. No new item is taken until
// the engine is back in idle; the finish state waits while the output is not free.
// Reset (synchronous) clears all valid marks and the entry count at once, no clearing
// pass; timeout_ms returns to 300000.
`default_nettype none

module address_resolution_cache
  import arc_pkg::*;
#(
  parameter int CACHE_ENTRIES = 16
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          cfg_wen,
  input  wire [31:0]   cfg_wdata,    // timeout_ms
  input  wire          s_tvalid,
  output logic         s_tready,
  input  wire [143:0]  s_tdata,      // ip_addr[31:0], mac_in[79:32], time_now[143:80]
  input  wire [1:0]    s_tuser,      // command
  output logic         m_tvalid,
  input  wire          m_tready,
  output logic [55:0]  m_tdata,      // mac_out[47:0], entry_count[52:48], zero pad
  output logic [2:0]   m_tuser       // status
);

  localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);

  logic [TO_W-1:0]  timeout_ms;
  req_t             eng_req;
  res_t             eng_res;
  logic             eng_ready;
  logic             eng_res_vld;
  logic [CNT_W-1:0] eng_count;
  logic             accept;
  logic             out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms <= TIMEOUT_RESET;
    end else if (cfg_wen) begin
      timeout_ms <= cfg_wdata;
    end
  end

  assign s_tready = eng_ready;
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign eng_req = '{command: s_tuser,
                     ip:      s_tdata[31:0],
                     mac:     s_tdata[79:32],
                     now:     s_tdata[143:80]};

  arc_engine #(
    .CACHE_ENTRIES(CACHE_ENTRIES)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .req_vld    (accept),
    .req        (eng_req),
    .timeout    (timeout_ms),
    .out_free   (out_free),
    .ready      (eng_ready),
    .res_vld    (eng_res_vld),
    .res        (eng_res),
    .valid_count(eng_count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (eng_res_vld) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_res_vld) begin
      m_tdata <= {3'b000, eng_res.count, eng_res.mac};
      m_tuser <= eng_res.status;
    end
  end

  // the engine is not ready in the cycle after taking a transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("engine ready right after accepting a transaction");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    eng_count <= CNT_W'(CACHE_ENTRIES))
    else $error("valid entry count exceeds table depth");

  a_result_lands: assert property (@(posedge clk) disable iff (rst)
    eng_res_vld |=> m_tvalid && (m_tuser == $past(eng_res.status)))
    else $error("engine result not presented on the output");

endmodule

`default_nettype wire

[sv/arc_entry_ram.sv]
// Entry storage: IP, hardware address and time stamp per slot.
// Single write port, single read port, registered read data. Uses arc_pkg.
`default_nettype none

module arc_entry_ram
  import arc_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire                                  clk,
  input  wire                                  we,
  input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  entry_t                               wdata,
  input  wire                                  ren,
  input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output entry_t                               rdata
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[sv/arc_engine.sv]
// Command sequencer: scans the entry RAM one slot per cycle, tracks match and free
// slot, ages entries on cleanup, writes back on add. Uses arc_pkg, arc_entry_ram.
`default_nettype none

module arc_engine
  import arc_pkg::*;
#(
  parameter int CACHE_ENTRIES = 16
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  req_vld,
  input  req_t                                 req,
  input  wire [TO_W-1:0]                       timeout,
  input  wire                                  out_free,
  output logic                                 ready,
  output logic                                 res_vld,
  output res_t                                 res,
  output logic [$clog2(CACHE_ENTRIES+1)-1:0]   valid_count
);

  localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0]               state;
  logic                     iss;
  logic                     chk_vld;
  logic [CACHE_ENTRIES-1:0] valid;
  logic [CNT_W-1:0]         count;

  req_t                     req_r;
  logic                     skip;
  logic [IDX_W-1:0]         rd_idx;
  logic [IDX_W-1:0]         chk_idx;
  logic                     match_found;
  logic [IDX_W-1:0]         match_idx;
  logic [MAC_W-1:0]         match_mac;
  logic                     free_found;
  logic [IDX_W-1:0]         free_idx;

  entry_t                   rdata;
  entry_t                   wdata;
  logic                     we;
  logic [IDX_W-1:0]         waddr;
  logic                     ren;

  logic                     ignore_in;
  logic                     finish_go;
  logic                     is_add;
  logic                     is_cleanup;
  logic                     slot_valid;
  logic                     ip_match;
  logic [STAMP_W-1:0]       age;
  logic                     expired;
  logic                     inserted;
  logic [CNT_W-1:0]         count_after;
  logic [CNT_W+COUNT_W-1:0] count_ext;

  assign ignore_in = (req.command == CMD_UNUSED) ||
                     (((req.command == CMD_ADD) || (req.command == CMD_LOOKUP)) &&
                      (req.ip == '0));

  assign is_add     = !skip && (req_r.command == CMD_ADD);
  assign is_cleanup = !skip && (req_r.command == CMD_CLEANUP);

  assign slot_valid = valid[chk_idx];
  assign ip_match   = slot_valid && (rdata.ip == req_r.ip);
  // wrapping age against the zero-extended timeout
  assign age        = req_r.now - rdata.stamp;
  assign expired    = slot_valid && (age >= {{(STAMP_W-TO_W){1'b0}}, timeout});

  assign finish_go = (state == S_FINISH) && out_free;
  assign inserted  = is_add && !match_found && free_found;

  assign ren   = (state == S_SCAN) && iss;
  assign we    = finish_go && is_add && (match_found || free_found);
  assign waddr = match_found ? match_idx : free_idx;
  assign wdata = '{ip: req_r.ip, mac: req_r.mac, stamp: req_r.now};

  arc_entry_ram #(
    .DEPTH(CACHE_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .ren  (ren),
    .raddr(rd_idx),
    .rdata(rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      iss     <= 1'b0;
      chk_vld <= 1'b0;
      valid   <= '0;
      count   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          chk_vld <= 1'b0;
          if (req_vld) begin
            if (ignore_in) begin
              state <= S_FINISH;
            end else begin
              iss   <= 1'b1;
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          chk_vld <= iss;
          if (iss && (rd_idx == LAST_IDX)) begin
            iss <= 1'b0;
          end
          if (chk_vld) begin
            if (is_cleanup && expired) begin
              valid[chk_idx] <= 1'b0;
              count          <= count - CNT_W'(1);
            end
            if (chk_idx == LAST_IDX) begin
              state <= S_FINISH;
            end
          end
        end
        S_FINISH: begin
          if (out_free) begin
            if (inserted) begin
              valid[free_idx] <= 1'b1;
              count           <= count + CNT_W'(1);
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // request and scan bookkeeping
  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && req_vld) begin
      req_r       <= req;
      skip        <= ignore_in;
      rd_idx      <= '0;
      match_found <= 1'b0;
      free_found  <= 1'b0;
    end else if (state == S_SCAN) begin
      chk_idx <= rd_idx;
      if (iss && (rd_idx != LAST_IDX)) begin
        rd_idx <= rd_idx + IDX_W'(1);
      end
      if (chk_vld) begin
        if (ip_match && !match_found) begin
          match_found <= 1'b1;
          match_idx   <= chk_idx;
          match_mac   <= rdata.mac;
        end
        if (!slot_valid && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= chk_idx;
        end
      end
    end
  end

  assign count_after = inserted ? count + CNT_W'(1) : count;
  assign count_ext   = {{COUNT_W{1'b0}}, count_after};

  always_comb begin
    res.status = ST_IGNORED;
    res.mac    = '0;
    res.count  = count_ext[COUNT_W-1:0];
    if (!skip) begin
      unique case (req_r.command)
        CMD_ADD: begin
          priority if (match_found) res.status = ST_REFRESHED;
          else if (free_found)      res.status = ST_INSERTED;
          else                      res.status = ST_FULL;
        end
        CMD_LOOKUP: begin
          res.status = match_found ? ST_HIT : ST_MISS;
          res.mac    = match_found ? match_mac : '0;
        end
        CMD_CLEANUP: res.status = ST_CLEANED;
        default:     res.status = ST_IGNORED;
      endcase
    end
  end

  assign ready       = (state == S_IDLE);
  assign res_vld     = finish_go;
  assign valid_count = count;

endmodule

`default_nettype wire
